// ===== src/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and microcode for the graph reachability core
// Word layouts for both channels, command codes, control word and status
// layouts, and the control store that sequences every command.
// ----------------------------------------------------------------------------
package gpr_pkg;

  // Width of the vertex count register and of the vertex fields
  localparam int NV_W  = 5;
  localparam int VTX_W = 4;

  // Command codes carried in the command field
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  // Input word
  typedef struct packed {
    logic [1:0]       command;
    logic [VTX_W-1:0] source;
    logic [VTX_W-1:0] target;
  } cmd_word_t;

  // Result word
  typedef struct packed {
    logic reachable;
    logic bad_index;
  } res_word_t;

  // Adjacency memory operation
  typedef enum logic [2:0] {
    ADJ_NONE,
    ADJ_CLEAR,
    ADJ_RD_SRC,
    ADJ_RD_NXT,
    ADJ_RD_POP,
    ADJ_WR_SRC
  } adj_op_t;

  // Search stack operation
  typedef enum logic [2:0] {
    STK_NONE,
    STK_INIT,
    STK_PUSH,
    STK_POP,
    STK_LOAD
  } stk_op_t;

  // Result register operation
  typedef enum logic [1:0] {
    RES_NONE,
    RES_DONE,
    RES_EMIT
  } res_op_t;

  // Branch conditions
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_CLEAR,
    COND_SKIP,
    COND_IS_ADD,
    COND_NO_FRESH,
    COND_DEPTH_ONE,
    COND_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Control store addresses
  localparam step_t S_FETCH     = 4'd0;
  localparam step_t S_DISP_CLR  = 4'd1;
  localparam step_t S_DISP_SKIP = 4'd2;
  localparam step_t S_DISP_ADD  = 4'd3;
  localparam step_t S_Q_INIT    = 4'd4;
  localparam step_t S_Q_EVAL    = 4'd5;
  localparam step_t S_Q_PUSH    = 4'd6;
  localparam step_t S_CLR       = 4'd7;
  localparam step_t S_WAIT      = 4'd8;
  localparam step_t S_EMIT      = 4'd9;
  localparam step_t S_ADD_RD    = 4'd10;
  localparam step_t S_ADD_WR    = 4'd11;
  localparam step_t S_Q_POP     = 4'd12;
  localparam step_t S_Q_LOAD    = 4'd13;
  localparam step_t S_Q_DONE    = 4'd14;

  // One control word per step
  typedef struct packed {
    logic    take;
    adj_op_t adj;
    stk_op_t stk;
    res_op_t res;
    cond_t   cond;
    step_t   target;
  } ucw_t;

  // Datapath flags the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic is_clear;
    logic skip;
    logic is_add;
    logic no_fresh;
    logic depth_one;
    logic out_busy;
  } status_t;

  function automatic ucw_t uw(input logic take, input adj_op_t adj, input stk_op_t stk,
                              input res_op_t res, input cond_t cond, input step_t target);
    ucw_t w;
    w.take   = take;
    w.adj    = adj;
    w.stk    = stk;
    w.res    = res;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store
  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    unique case (step)
      S_FETCH:     w = uw(1'b1, ADJ_NONE,   STK_NONE, RES_NONE, COND_NO_INPUT,  S_FETCH);
      S_DISP_CLR:  w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_IS_CLEAR,  S_CLR);
      S_DISP_SKIP: w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_SKIP,      S_WAIT);
      S_DISP_ADD:  w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_IS_ADD,    S_ADD_RD);
      S_Q_INIT:    w = uw(1'b0, ADJ_RD_SRC, STK_INIT, RES_NONE, COND_NEXT,      S_FETCH);
      S_Q_EVAL:    w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_NO_FRESH,  S_Q_POP);
      S_Q_PUSH:    w = uw(1'b0, ADJ_RD_NXT, STK_PUSH, RES_NONE, COND_ALWAYS,    S_Q_EVAL);
      S_CLR:       w = uw(1'b0, ADJ_CLEAR,  STK_NONE, RES_NONE, COND_ALWAYS,    S_WAIT);
      S_WAIT:      w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_OUT_BUSY,  S_WAIT);
      S_EMIT:      w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_EMIT, COND_ALWAYS,    S_FETCH);
      S_ADD_RD:    w = uw(1'b0, ADJ_RD_SRC, STK_NONE, RES_NONE, COND_NEXT,      S_FETCH);
      S_ADD_WR:    w = uw(1'b0, ADJ_WR_SRC, STK_NONE, RES_NONE, COND_ALWAYS,    S_WAIT);
      S_Q_POP:     w = uw(1'b0, ADJ_NONE,   STK_POP,  RES_NONE, COND_DEPTH_ONE, S_Q_DONE);
      S_Q_LOAD:    w = uw(1'b0, ADJ_RD_POP, STK_LOAD, RES_NONE, COND_ALWAYS,    S_Q_EVAL);
      S_Q_DONE:    w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_DONE, COND_ALWAYS,    S_WAIT);
      default:     w = uw(1'b0, ADJ_NONE,   STK_NONE, RES_NONE, COND_ALWAYS,    S_FETCH);
    endcase
    return w;
  endfunction

endpackage

// ===== src/gpr_stream_if.sv =====
// ----------------------------------------------------------------------------
// gpr_stream_if: valid/ready channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface gpr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/gpr_useq.sv =====
// ----------------------------------------------------------------------------
// gpr_useq: microcode sequencer
// Step counter over the control store, with conditional jumps taken on the
// datapath status flags.
// ----------------------------------------------------------------------------
module gpr_useq (
  input  logic              clk,
  input  logic              rst,
  input  gpr_pkg::status_t  st,
  output gpr_pkg::ucw_t     ctrl
);
  import gpr_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  // Fetch the control word for the current step
  assign ctrl = ucode_rom(step);

  // Evaluate the branch condition
  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:      taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_INPUT:  taken = !st.in_valid;
      COND_IS_CLEAR:  taken = st.is_clear;
      COND_SKIP:      taken = st.skip;
      COND_IS_ADD:    taken = st.is_add;
      COND_NO_FRESH:  taken = st.no_fresh;
      COND_DEPTH_ONE: taken = st.depth_one;
      COND_OUT_BUSY:  taken = st.out_busy;
      default:        taken = 1'b0;
    endcase
  end

  assign step_next = taken ? ctrl.target : step + step_t'(1);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // Hold at fetch until a word arrives
  a_fetch_hold: assert property (@(posedge clk) disable iff (rst)
    (step == S_FETCH && !st.in_valid) |=> step == S_FETCH)
    else $error("sequencer left fetch without a word");

  // A vertex with no fresh neighbour is popped
  a_eval_pop: assert property (@(posedge clk) disable iff (rst)
    (step == S_Q_EVAL && st.no_fresh) |=> step == S_Q_POP)
    else $error("exhausted vertex not popped");

  // Popping the last entry ends the search
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    (step == S_Q_POP && st.depth_one) |=> step == S_Q_DONE)
    else $error("search did not end on empty stack");

endmodule

// ===== src/gpr_dpath.sv =====
// ----------------------------------------------------------------------------
// gpr_dpath: datapath of the graph reachability core
// Adjacency memory with per-row valid bits, visited marks, search stack
// memory with a top-of-stack register, and the result register.
// ----------------------------------------------------------------------------
module gpr_dpath #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [gpr_pkg::NV_W-1:0] num_vertices,
  input  gpr_pkg::ucw_t            ctrl,
  output gpr_pkg::status_t         st,
  gpr_stream_if.sink               cmd,
  gpr_stream_if.source             res
);
  import gpr_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] ONE_V = MAX_VERTICES'(1);

  // Command latch
  cmd_word_t item;
  logic      bad;
  logic      reach;
  logic      in_fire;
  logic      in_bad;
  logic [DW-1:0] cnt;
  logic [MAX_VERTICES-1:0] cnt_mask;

  // Search state
  logic [VW-1:0]           src_v;
  logic [VW-1:0]           dst_v;
  logic [VW-1:0]           top;
  logic [DW-1:0]           depth;
  logic [DW-1:0]           depth_m1;
  logic [DW-1:0]           depth_m2;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] fresh;
  logic [VW-1:0]           nxt;

  // Memories
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_valid;
  logic [MAX_VERTICES-1:0] row;
  logic                    row_ok;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [VW-1:0]           adj_raddr;
  logic                    adj_rd;
  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_rdata;

  // Result register
  logic      out_valid;
  res_word_t out_word;
  logic      out_busy;

  // Effective vertex count and neighbour mask
  always_comb begin
    if (32'(num_vertices) > MAX_VERTICES) begin
      cnt = DW'(MAX_VERTICES);
    end else begin
      cnt = DW'(num_vertices);
    end
    for (int j = 0; j < MAX_VERTICES; j++) begin
      cnt_mask[j] = (32'(j) < 32'(cnt));
    end
  end

  assign in_fire = cmd.valid && cmd.ready;
  assign in_bad  = ((cmd.payload.command == CMD_ADD) || (cmd.payload.command == CMD_QUERY)) &&
                   ((32'(cmd.payload.source) >= 32'(cnt)) ||
                    (32'(cmd.payload.target) >= 32'(cnt)));

  assign src_v    = VW'(item.source);
  assign dst_v    = VW'(item.target);
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);

  // Pick the lowest fresh neighbour of the top vertex
  assign row_eff = row_ok ? row : '0;
  assign fresh   = row_eff & ~visited & cnt_mask;
  always_comb begin
    nxt = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (fresh[j]) begin
        nxt = VW'(j);
      end
    end
  end

  // Select the adjacency read row
  always_comb begin
    adj_rd    = 1'b1;
    adj_raddr = src_v;
    unique case (ctrl.adj)
      ADJ_RD_SRC: adj_raddr = src_v;
      ADJ_RD_NXT: adj_raddr = nxt;
      ADJ_RD_POP: adj_raddr = stk_rdata;
      default:    adj_rd    = 1'b0;
    endcase
  end

  // Adjacency memory: one read, one write
  always_ff @(posedge clk) begin
    if (adj_rd) begin
      row <= adj_mem[adj_raddr];
    end
    if (ctrl.adj == ADJ_WR_SRC) begin
      adj_mem[src_v] <= row_eff | (ONE_V << dst_v);
    end
  end

  // Row valid bits: clear drops all rows at once
  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= '0;
      row_ok    <= 1'b0;
    end else begin
      if (adj_rd) begin
        row_ok <= adj_valid[adj_raddr];
      end
      if (ctrl.adj == ADJ_CLEAR) begin
        adj_valid <= '0;
      end else if (ctrl.adj == ADJ_WR_SRC) begin
        adj_valid[src_v] <= 1'b1;
      end
    end
  end

  // Search stack memory: push writes old top, pop reads the new top
  always_ff @(posedge clk) begin
    if (ctrl.stk == STK_PUSH) begin
      stk_mem[depth_m1[VW-1:0]] <= top;
    end
    if (ctrl.stk == STK_POP) begin
      stk_rdata <= stk_mem[depth_m2[VW-1:0]];
    end
  end

  // Stack depth, top and visited marks
  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      visited <= '0;
      top     <= '0;
    end else begin
      unique case (ctrl.stk)
        STK_INIT: begin
          depth   <= DW'(1);
          top     <= src_v;
          visited <= ONE_V << src_v;
        end
        STK_PUSH: begin
          depth   <= depth + DW'(1);
          top     <= nxt;
          visited <= visited | (ONE_V << nxt);
        end
        STK_POP: begin
          depth <= depth_m1;
        end
        STK_LOAD: begin
          top <= stk_rdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the command word and its flags
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item  <= cmd.payload;
      bad   <= in_bad;
      reach <= 1'b0;
    end else if (ctrl.res == RES_DONE) begin
      reach <= visited[dst_v];
    end
  end

  // Output register
  assign out_busy = out_valid && !res.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.res == RES_EMIT) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res == RES_EMIT) begin
      out_word.reachable <= reach;
      out_word.bad_index <= bad;
    end
  end

  assign cmd.ready   = ctrl.take;
  assign res.valid   = out_valid;
  assign res.payload = out_word;

  // Status toward the sequencer
  assign st.in_valid  = cmd.valid;
  assign st.is_clear  = (item.command == CMD_CLEAR);
  assign st.skip      = (item.command == CMD_NOP) || bad;
  assign st.is_add    = (item.command == CMD_ADD);
  assign st.no_fresh  = (fresh == '0);
  assign st.depth_one = (depth == DW'(1));
  assign st.out_busy  = out_busy;

  // Each vertex is pushed at most once
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl.stk == STK_PUSH) |-> (32'(depth) < MAX_VERTICES))
    else $error("search stack overflow");

  // Never pop an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.stk == STK_POP) |-> (depth != '0))
    else $error("pop on empty search stack");

  // A result is loaded only into a free register and then shows as valid
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.res == RES_EMIT) |-> !out_busy ##1 res.valid)
    else $error("result overwrote a pending word");

endmodule

// ===== src/graph_path_reachability_core.sv =====
// ----------------------------------------------------------------------------
// graph_path_reachability_core: directed graph reachability engine
// Holds an adjacency bit matrix and answers path queries by depth-first
// search, sequenced by a small control store.
// ----------------------------------------------------------------------------
// Use:
//   cmd  (sink)   one command word per handshake: clear all edges, add edge
//                 source->target, or query whether target is reachable from
//                 source. Command 3 does nothing.
//   res  (source) exactly one result word per command, in order.
//   cfg_we/cfg_wdata write the vertex count; write it only while idle.
// Sequencing, one command at a time:
//   clear drops every row, rejected or no-op words skip to the result, add
//   edge reads the source row and writes it back with the target bit set.
//   The search steps through the microcode loop: two steps per push (scan,
//   push) and three per pop (scan, pop, reload top from the stack memory).
//   cmd is ready only at the fetch step, after the previous result is
//   handed to the output register.
// A result waits in the output register while res stalls; the next command
// is accepted meanwhile and its result waits until the register is free.
// Reset empties the graph, zeroes the vertex count and drops any result.
// ----------------------------------------------------------------------------
module graph_path_reachability_core #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [gpr_pkg::NV_W-1:0] cfg_wdata,
  gpr_stream_if.sink               cmd,
  gpr_stream_if.source             res
);
  import gpr_pkg::*;

  logic [NV_W-1:0] num_vertices;
  ucw_t            ctrl;
  status_t         st;

  // Vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= '0;
    end else if (cfg_we) begin
      num_vertices <= cfg_wdata;
    end
  end

  gpr_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  gpr_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .num_vertices (num_vertices),
    .ctrl         (ctrl),
    .st           (st),
    .cmd          (cmd),
    .res          (res)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for graph_path_reachability_core
// Drives clear, add-edge, query and no-op words into the command channel,
// first from a short table and then at random over several vertex counts
// and idling mixes. Each answer word is checked field by field, against the
// table for typed rows, else against a depth-first search on a graph copy.
// ----------------------------------------------------------------------------
module tb_top;
  import gpr_pkg::*;

  localparam int VTX_MAX    = 16;
  localparam int QUIET_MAX  = 3000;
  localparam int TAIL_WAIT  = 100;
  localparam int PHASE_LEN  = 180;
  localparam int NUM_PHASES = 8;

  // One row of the directed table; nv_before < 0 keeps the vertex count
  typedef struct packed {
    int        nv_before;
    cmd_word_t word;
    logic      typed;
    res_word_t answer;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [NV_W-1:0]     cfg_wdata;

  gpr_stream_if #(.payload_t(cmd_word_t)) cmd_if ();
  gpr_stream_if #(.payload_t(res_word_t)) res_if ();

  // Private copy of the graph and the vertex count
  logic [VTX_MAX-1:0]  edge_rows [VTX_MAX];
  logic [NV_W-1:0]     vtx_limit;

  res_word_t           pending_answers [$];
  int                  fail_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  quiet_cycles = 0;

  dir_row_t directed_rows [24] = '{
    '{-1, '{CMD_QUERY, 4'd0,  4'd0},  1'b1, '{1'b0, 1'b1}},
    '{-1, '{CMD_ADD,   4'd15, 4'd15}, 1'b1, '{1'b0, 1'b1}},
    '{-1, '{CMD_NOP,   4'd15, 4'd15}, 1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_CLEAR, 4'd0,  4'd0},  1'b1, '{1'b0, 1'b0}},
    '{16, '{CMD_QUERY, 4'd5,  4'd5},  1'b1, '{1'b1, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd0,  4'd15}, 1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd0,  4'd1},  1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd1,  4'd15}, 1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd1,  4'd15}, 1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd15, 4'd0},  1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd0,  4'd15}, 1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd15, 4'd1},  1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd15, 4'd15}, 1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd15, 4'd15}, 1'b1, '{1'b1, 1'b0}},
    '{2,  '{CMD_QUERY, 4'd0,  4'd1},  1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd1,  4'd0},  1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_ADD,   4'd0,  4'd2},  1'b1, '{1'b0, 1'b1}},
    '{-1, '{CMD_QUERY, 4'd2,  4'd0},  1'b1, '{1'b0, 1'b1}},
    '{31, '{CMD_QUERY, 4'd0,  4'd15}, 1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_CLEAR, 4'd0,  4'd0},  1'b1, '{1'b0, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd0,  4'd15}, 1'b0, '{1'b0, 1'b0}},
    '{-1, '{CMD_NOP,   4'd10, 4'd5},  1'b1, '{1'b0, 1'b0}},
    '{1,  '{CMD_QUERY, 4'd0,  4'd0},  1'b1, '{1'b1, 1'b0}},
    '{-1, '{CMD_QUERY, 4'd0,  4'd1},  1'b1, '{1'b0, 1'b1}}
  };

  graph_path_reachability_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  always #5 clk = ~clk;

  // Apply one command to the private graph and return the answer it earns
  function automatic res_word_t predict_answer(input cmd_word_t w);
    res_word_t          r;
    int                 cnt;
    int                 depth;
    int                 nxt;
    int                 j;
    logic [3:0]         top;
    logic [3:0]         dfs_stack [VTX_MAX];
    logic [VTX_MAX-1:0] reached;
    r = '0;
    cnt = (vtx_limit > VTX_MAX) ? VTX_MAX : int'(vtx_limit);
    case (cmd_code_t'(w.command))
      CMD_CLEAR: begin
        for (j = 0; j < VTX_MAX; j++) edge_rows[j] = '0;
      end
      CMD_ADD, CMD_QUERY: begin
        if (int'(w.source) >= cnt || int'(w.target) >= cnt) begin
          r.bad_index = 1'b1;
        end else if (cmd_code_t'(w.command) == CMD_ADD) begin
          edge_rows[w.source][w.target] = 1'b1;
        end else begin
          // Explicit-stack search, lowest fresh neighbor first
          reached = '0;
          reached[w.source] = 1'b1;
          dfs_stack[0] = w.source;
          depth = 1;
          while (depth > 0) begin
            top = dfs_stack[depth-1];
            nxt = cnt;
            for (j = 0; j < cnt; j++) begin
              if (edge_rows[top][j] && !reached[j]) begin
                nxt = j;
                break;
              end
            end
            if (nxt == cnt) begin
              depth--;
            end else begin
              reached[nxt] = 1'b1;
              dfs_stack[depth] = nxt[3:0];
              depth++;
            end
          end
          r.reachable = reached[w.target];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Offer one word, idle first at random, and queue its answer on accept
  task automatic send_word(input cmd_word_t w, input logic typed, input res_word_t answer);
    res_word_t predicted;
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= w;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = predict_answer(w);
    pending_answers.push_back(typed ? answer : predicted);
  endtask

  // Hold off the sender until every answer has come back
  task automatic drain_answers();
    cmd_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [NV_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    vtx_limit = v;
  endtask

  function automatic logic [3:0] pick_vertex(input int cnt);
    if (cnt > 0 && $urandom_range(9, 0) != 0) return 4'($urandom_range(cnt - 1, 0));
    return 4'($urandom_range(15, 0));
  endfunction

  // Mostly adds and queries over existing vertices, with clears and noise
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        cnt;
    int        pick;
    cnt = (vtx_limit > VTX_MAX) ? VTX_MAX : int'(vtx_limit);
    pick = $urandom_range(99, 0);
    if (pick < 5) w.command = CMD_CLEAR;
    else if (pick < 9) w.command = CMD_NOP;
    else if (pick < 50) w.command = CMD_ADD;
    else w.command = CMD_QUERY;
    w.source = pick_vertex(cnt);
    w.target = pick_vertex(cnt);
    return w;
  endfunction

  // Drive the answer-side ready with random stalls
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Check each accepted answer word against the oldest prediction
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_answers.size() == 0) begin
        report("answer word with nothing pending");
      end else begin
        want = pending_answers.pop_front();
        if (res_if.payload.reachable !== want.reachable)
          report($sformatf("reachable got %b want %b",
                           res_if.payload.reachable, want.reachable));
        if (res_if.payload.bad_index !== want.bad_index)
          report($sformatf("bad_index got %b want %b",
                           res_if.payload.bad_index, want.bad_index));
      end
    end
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no word moved in %0d cycles", QUIET_MAX);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          p;
    int          i;
    logic [4:0]  phase_nv [NUM_PHASES];
    phase_nv = '{5'd16, 5'd5, 5'd31, 5'd2, 5'd16, 5'($urandom_range(31, 0)), 5'd9, 5'd16};
    for (i = 0; i < VTX_MAX; i++) edge_rows[i] = '0;
    vtx_limit = '0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].nv_before >= 0) begin
        drain_answers();
        set_vertex_count(directed_rows[i].nv_before[NV_W-1:0]);
      end
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);
    end

    // Random phases over vertex counts and idling mixes
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_answers();
      set_vertex_count(phase_nv[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (i = 0; i < PHASE_LEN; i++) begin
        if (i == PHASE_LEN / 2) drain_answers();
        send_word(random_word(), 1'b0, '0);
      end
    end

    drain_answers();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
